// ===== design/boundary_plausibility_check_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the boundary plausibility check
// ---------------------------------------------------------------------------
`ifndef BOUNDARY_PLAUSIBILITY_CHECK_UNIT_DEFINES_SVH
`define BOUNDARY_PLAUSIBILITY_CHECK_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define BPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpc check failed");

// implication whose consequent is checked in the next cycle
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpc check failed");

`endif

// ===== design/bpc_pkg.sv =====
// ---------------------------------------------------------------------------
// bpc_pkg
// Shared constants and types of the boundary plausibility check.
// ---------------------------------------------------------------------------
package bpc_pkg;

	localparam int MaxSpots  = 64;
	localparam int AddrW     = $clog2(MaxSpots);
	localparam int CntW      = $clog2(MaxSpots + 1);
	localparam int HeadSpots = 3;
	localparam int RowW      = 10;
	localparam int UncW      = 24;
	localparam int UTotW     = UncW + CntW;
	localparam int DevW      = 26;
	localparam int DepthW    = RowW + CntW;
	localparam int NumW      = 22;
	localparam int QuoW      = NumW + 8;
	localparam logic [DevW-1:0] DevSat = {DevW{1'b1}};

	typedef enum logic [2:0] {
		REG_TOP_LINE   = 3'd0,
		REG_MIN_SHARE  = 3'd1,
		REG_UNC_LIMIT  = 3'd2,
		REG_BELOW_LIM  = 3'd3,
		REG_JAG_LIMIT  = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_DEPTH_DIV,
		ST_REPORT
	} bpc_state_t;

	// restoring divider request/response
	typedef struct packed {
		logic            start;
		logic [QuoW-1:0] dividend;
		logic [QuoW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [QuoW-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== design/bpc_divider.sv =====
// ---------------------------------------------------------------------------
// bpc_divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bpc_divider
	import bpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int StepW = $clog2(QuoW + 1);

	logic [QuoW-1:0]  quo_q;
	logic [QuoW-1:0]  rem_q;
	logic [QuoW-1:0]  den_q;
	logic [StepW-1:0] step_q;
	logic             busy_q;
	logic             done_q;
	logic [QuoW:0]    trial;

	assign trial = {rem_q, quo_q[QuoW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= StepW'(QuoW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[QuoW]) begin
				rem_q <= trial[QuoW-1:0];
				quo_q <= {quo_q[QuoW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[QuoW-2:0], quo_q[QuoW-1]};
				quo_q <= {quo_q[QuoW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== design/bpc_row_ram.sv =====
// ---------------------------------------------------------------------------
// bpc_row_ram
// Row store of counted spots, one write and one registered read port.
// ---------------------------------------------------------------------------
module bpc_row_ram
	import bpc_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [RowW-1:0]  wr_data,
	input  logic [AddrW-1:0] rd_addr,
	output logic [RowW-1:0]  rd_data
);

	logic [RowW-1:0] mem [MaxSpots];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/boundary_plausibility_check_unit.sv =====
// ---------------------------------------------------------------------------
// boundary_plausibility_check_unit
// Plausibility check of a list of boundary spots.
// ---------------------------------------------------------------------------
// Usage: spots enter on the s_axis channel, one beat per spot; tlast marks
// the final spot. One verdict beat leaves on m_axis per list. Registers are
// written through the cfg channel (index, data) while the block is idle; the
// user must ensure it, as the block does not enforce it. A spot whose triple
// has a non-zero dx holds the input until its deviation term is through the
// shared restoring divider, one quotient bit per cycle over 30 bits; any
// other spot leaves the next slot free. At the end of a list the row store
// is scanned, one entry per cycle through its registered read port, then the
// mean depth is divided; the verdict is registered once its register frees.
// A list with fewer than three spots or no counted spot skips scan and divide.
// If the receiver stalls, a verdict waits in its output register while the
// next list is taken in; that list's verdict waits until the register frees.
// Reset clears the counters and returns the registers to their defaults; the
// row store needs no clearing.
// ---------------------------------------------------------------------------
`include "boundary_plausibility_check_unit_defines.svh"

module boundary_plausibility_check_unit
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // spot_x, spot_y, spot_uncertainty, pad
	input  logic        s_axis_tlast,   // last_spot
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // is_odd, share_low, uncertainty_high,
	                                    // below_border_high, jagged_high, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic [RowW-1:0]  top_line_q;
	logic [8:0]       min_share_q;
	logic [UncW-1:0]  unc_limit_q;
	logic [RowW-1:0]  below_lim_q;
	logic [17:0]      jag_limit_q;

	bpc_state_t       state_q, state_d;

	logic [CntW-1:0]  spot_cnt_q;
	logic [CntW-1:0]  cnt_q;
	logic [UTotW-1:0] utot_q;
	logic [DevW-1:0]  dev_q;
	logic [RowW-1:0]  x0_q, y0_q, x1_q, y1_q, third_q, head_q;
	logic             c0_q, c1_q;
	logic             last_q;
	logic [CntW-1:0]  scan_q;
	logic             scan_v_s1;
	logic [DepthW-1:0] depth_q;
	logic [4:0]       res_q;
	logic             out_v_q;

	logic [RowW-1:0]  in_x, in_y;
	logic [UncW-1:0]  in_u;
	logic             accept, take, counted, report_go;
	logic [RowW-1:0]  rd_data;
	div_req_t         dreq;
	div_rsp_t         drsp;

	logic signed [RowW+1:0] dx, dxb, dy1, dy2;
	logic signed [NumW:0]   num;
	logic [NumW-1:0]        mag;
	logic [RowW:0]          adx;
	logic                   triple;
	logic [QuoW:0]          dev_sum;
	logic [RowW-1:0]        ym_a, ym_b, ymax_c;
	logic                   is_short, no_cnt, share, unc, jag, below;

	assign in_x = s_axis_tdata[9:0];
	assign in_y = s_axis_tdata[19:10];
	assign in_u = s_axis_tdata[43:20];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign take    = m_axis_tvalid && m_axis_tready;
	assign report_go = (state_q == ST_REPORT) && (!out_v_q || take);
	assign cfg_ready = 1'b1;
	assign counted = in_y > top_line_q;
	assign triple  = (spot_cnt_q < CntW'(MaxSpots)) && (spot_cnt_q >= CntW'(2)) && c1_q;

	// triple term: a = recent 1, b = recent 0, c = incoming
	assign dx  = $signed({2'b0, x1_q}) - $signed({2'b0, in_x});
	assign dxb = $signed({2'b0, x0_q}) - $signed({2'b0, x1_q});
	assign dy1 = $signed({2'b0, y1_q}) - $signed({2'b0, y0_q});
	assign dy2 = $signed({2'b0, y1_q}) - $signed({2'b0, in_y});
	assign num = (NumW+1)'(dy1 * dx) + (NumW+1)'(dy2 * dxb);
	assign mag = num[NumW] ? NumW'(-num) : NumW'(num);
	assign adx = dx[RowW+1] ? (RowW+1)'(-dx) : (RowW+1)'(dx);

	always_comb begin
		dreq = '0;
		if (accept && triple && adx != '0) begin
			dreq.start    = 1'b1;
			dreq.dividend = {mag, 8'b0};
			dreq.divisor  = QuoW'(adx);
		end else if (state_q == ST_SCAN && scan_q > cnt_q && !scan_v_s1
				&& cnt_q != '0 && spot_cnt_q >= CntW'(HeadSpots)) begin
			dreq.start    = 1'b1;
			dreq.dividend = QuoW'(depth_q);
			dreq.divisor  = QuoW'(cnt_q);
		end
	end

	bpc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	bpc_row_ram u_ram (
		.clk     (clk),
		.wr_en   (accept && spot_cnt_q < CntW'(MaxSpots) && counted),
		.wr_addr (cnt_q[AddrW-1:0]),
		.wr_data (in_y),
		.rd_addr (scan_q[AddrW-1:0]),
		.rd_data (rd_data)
	);

	assign ym_a   = (head_q > third_q) ? head_q : third_q;
	assign ym_b   = (y0_q > y1_q) ? y0_q : y1_q;
	assign ymax_c = (ym_a > ym_b) ? ym_a : ym_b;

	assign is_short = spot_cnt_q < CntW'(HeadSpots);
	assign no_cnt   = cnt_q == '0;
	assign share    = ({cnt_q, 8'b0}) < (min_share_q * spot_cnt_q);
	assign unc      = utot_q > UTotW'(unc_limit_q * cnt_q);
	assign jag      = DevW'(dev_q) > DevW'(jag_limit_q * cnt_q);
	assign below    = drsp.quotient > QuoW'(below_lim_q);
	assign dev_sum  = (QuoW+1)'(dev_q) + (QuoW+1)'(drsp.quotient);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && triple && adx != '0)
					state_d = ST_DIV;
				else if (accept && s_axis_tlast)
					state_d = ST_SCAN;
			end
			ST_DIV: begin
				if (drsp.done)
					state_d = last_q ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (is_short || no_cnt)
					state_d = ST_REPORT;
				else if (dreq.start)
					state_d = ST_DEPTH_DIV;
			end
			ST_DEPTH_DIV: begin
				if (drsp.done)
					state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (report_go)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_line_q  <= '0;
			min_share_q <= 9'd128;
			unc_limit_q <= 24'd2560;
			below_lim_q <= 10'd20;
			jag_limit_q <= 18'd1280;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TOP_LINE:  top_line_q  <= cfg_data[9:0];
				REG_MIN_SHARE: min_share_q <= cfg_data[8:0];
				REG_UNC_LIMIT: unc_limit_q <= cfg_data;
				REG_BELOW_LIM: below_lim_q <= cfg_data[9:0];
				REG_JAG_LIMIT: jag_limit_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spot_cnt_q <= '0;
			cnt_q      <= '0;
			utot_q     <= '0;
			dev_q      <= '0;
			x0_q <= '0; y0_q <= '0; c0_q <= 1'b0;
			x1_q <= '0; y1_q <= '0; c1_q <= 1'b0;
			third_q <= '0; head_q <= '0;
			last_q  <= 1'b0;
			scan_q  <= '0;
			scan_v_s1 <= 1'b0;
			depth_q <= '0;
			res_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (report_go)
				out_v_q <= 1'b1;
			else if (take)
				out_v_q <= 1'b0;
			if (accept) begin
				last_q <= s_axis_tlast;
				scan_q <= '0;
				scan_v_s1 <= 1'b0;
				depth_q <= '0;
				if (spot_cnt_q < CntW'(MaxSpots)) begin
					if (spot_cnt_q < CntW'(HeadSpots) && in_y > head_q)
						head_q <= in_y;
					if (counted) begin
						cnt_q  <= cnt_q + 1'b1;
						utot_q <= utot_q + UTotW'(in_u);
					end
					third_q <= y1_q;
					x1_q <= x0_q; y1_q <= y0_q; c1_q <= c0_q;
					x0_q <= in_x; y0_q <= in_y; c0_q <= counted;
					spot_cnt_q <= spot_cnt_q + 1'b1;
				end
			end
			if (state_q == ST_DIV && drsp.done)
				dev_q <= (dev_sum > (QuoW+1)'(DevSat)) ? DevSat : dev_sum[DevW-1:0];
			if (state_q == ST_SCAN) begin
				if (scan_q <= cnt_q) begin
					scan_q <= scan_q + 1'b1;
					scan_v_s1 <= scan_q < cnt_q;
				end else begin
					scan_v_s1 <= 1'b0;
				end
				if (scan_v_s1 && rd_data > ymax_c)
					depth_q <= depth_q + DepthW'(rd_data - ymax_c);
			end
			if (report_go) begin
				if (is_short)
					res_q <= 5'b00001;
				else if (no_cnt)
					res_q <= {3'b000, share, 1'b1};
				else
					res_q <= {jag, below, unc, share, share | unc | below | jag};
				spot_cnt_q <= '0;
				cnt_q <= '0; utot_q <= '0; dev_q <= '0;
				x0_q <= '0; y0_q <= '0; c0_q <= 1'b0;
				x1_q <= '0; y1_q <= '0; c1_q <= 1'b0;
				third_q <= '0; head_q <= '0;
				last_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'b000, res_q};

	`BPC_ASSERT_IMP(a_no_accept_busy, state_q != ST_IDLE, !s_axis_tready)
	`BPC_ASSERT_NEXT(a_report_valid, state_q == ST_REPORT, m_axis_tvalid)
	`BPC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= spot_cnt_q)

endmodule

// ===== verif/boundary_plausibility_check_unit_test.sv =====
// ---------------------------------------------------------------------------
// boundary_plausibility_check_unit_test
// Self-checking bench for the boundary plausibility check. Spot lists go in
// on s_axis in random bursts while the verdict side stalls on its own
// pattern. A model inside the bench predicts each verdict, and every verdict
// beat is compared field by field. Register settings change between phases
// and include both extremes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module boundary_plausibility_check_unit_test;
	import bpc_pkg::*;

	localparam logic [2:0] RegUnused = 3'd7;
	localparam int CycleLimit = 1000000;
	localparam int SettleCycles = 200;

	typedef struct packed {
		logic jagged_high;
		logic below_border_high;
		logic uncertainty_high;
		logic share_low;
		logic is_odd;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // spot_x, spot_y, spot_uncertainty, pad
	logic        s_axis_tlast = 1'b0; // last_spot
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // is_odd, share_low, uncertainty_high,
	                                  // below_border_high, jagged_high, pad
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	boundary_plausibility_check_unit u_dut (.*);

	// predictor state
	logic [9:0]  top_line_q;
	logic [8:0]  min_share_q;
	logic [23:0] unc_limit_q;
	logic [9:0]  below_limit_q;
	logic [17:0] jag_limit_q;
	logic [9:0]  row_mem [MaxSpots];
	int          n_spots;
	int          n_counted;
	longint      unc_sum;
	longint      dev_sum;
	logic [9:0]  prev_x [2];
	logic [9:0]  prev_y [2];
	logic        prev_c [2];
	logic [9:0]  third_row;
	logic [9:0]  head_max;

	verdict_t    pending_verdicts [$];
	int          error_count = 0;
	int          spots_sent = 0;
	int          burst_left = 0;
	int          hold_req = 0;
	int          hold_cnt = 0;
	int          cycle_cnt = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// receiver: stall pattern cycles through four modes, long hold-off on request
	always @(posedge clk) begin
		int mode;
		mode = (cycle_cnt / 64) % 4;
		if (hold_req != 0) begin
			hold_cnt = 3000;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ((cycle_cnt % 23) > 17);
			endcase
		end
	end

	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = verdict_t'(m_axis_tdata[4:0]);
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unexpected verdict", int'(m_axis_tdata), -1);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.is_odd != want.is_odd)
					report_mismatch("is_odd", got.is_odd, want.is_odd);
				if (got.share_low != want.share_low)
					report_mismatch("share_low", got.share_low, want.share_low);
				if (got.uncertainty_high != want.uncertainty_high)
					report_mismatch("uncertainty_high", got.uncertainty_high,
						want.uncertainty_high);
				if (got.below_border_high != want.below_border_high)
					report_mismatch("below_border_high", got.below_border_high,
						want.below_border_high);
				if (got.jagged_high != want.jagged_high)
					report_mismatch("jagged_high", got.jagged_high, want.jagged_high);
			end
		end
	end

	function automatic void clear_list();
		n_spots = 0;
		n_counted = 0;
		unc_sum = 0;
		dev_sum = 0;
		prev_x = '{default: '0};
		prev_y = '{default: '0};
		prev_c = '{default: 1'b0};
		third_row = '0;
		head_max = '0;
	endfunction

	function automatic longint deviation_term(input logic [9:0] x2, input logic [9:0] y2);
		longint x0, y0, x1, y1, dx, num;
		x0 = prev_x[1];
		y0 = prev_y[1];
		x1 = prev_x[0];
		y1 = prev_y[0];
		dx = x0 - longint'(x2);
		if (dx == 0)
			return 0;
		num = (y0 - y1) * dx + (y0 - longint'(y2)) * (x1 - x0);
		if (num < 0)
			num = -num;
		if (dx < 0)
			dx = -dx;
		return (num * 256) / dx;
	endfunction

	function automatic void predict_verdict(input logic [9:0] x, input logic [9:0] y,
			input logic [23:0] u, input logic last);
		verdict_t v;
		logic counted;
		logic [9:0] ymax;
		longint depth;
		if (n_spots < MaxSpots) begin
			counted = y > top_line_q;
			if (n_spots < HeadSpots && y > head_max)
				head_max = y;
			if (counted) begin
				row_mem[n_counted] = y;
				n_counted++;
				unc_sum += u;
			end
			if (n_spots >= 2 && prev_c[1]) begin
				dev_sum += deviation_term(x, y);
				if (dev_sum > longint'(DevSat))
					dev_sum = DevSat;
			end
			third_row = prev_y[1];
			prev_x[1] = prev_x[0];
			prev_y[1] = prev_y[0];
			prev_c[1] = prev_c[0];
			prev_x[0] = x;
			prev_y[0] = y;
			prev_c[0] = counted;
			n_spots++;
		end
		if (!last)
			return;
		v = '0;
		if (n_spots < HeadSpots) begin
			v.is_odd = 1'b1;
		end else begin
			v.share_low = longint'(n_counted) * 256 < longint'(min_share_q) * n_spots;
			if (n_counted == 0) begin
				v.is_odd = 1'b1;
			end else begin
				ymax = head_max;
				if (third_row > ymax) ymax = third_row;
				if (prev_y[0] > ymax) ymax = prev_y[0];
				if (prev_y[1] > ymax) ymax = prev_y[1];
				depth = 0;
				for (int i = 0; i < n_counted; i++)
					if (row_mem[i] > ymax)
						depth += row_mem[i] - ymax;
				v.uncertainty_high = unc_sum > longint'(unc_limit_q) * n_counted;
				v.below_border_high = depth / n_counted > below_limit_q;
				v.jagged_high = dev_sum > longint'(jag_limit_q) * n_counted;
				v.is_odd = v.share_low | v.uncertainty_high | v.below_border_high
					| v.jagged_high;
			end
		end
		pending_verdicts = {pending_verdicts, v};
		clear_list();
	endfunction

	task automatic send_spot(input logic [9:0] x, input logic [9:0] y,
			input logic [23:0] u, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, u, y, x};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_verdict(x, y, u, last);
		spots_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TOP_LINE:  top_line_q = value[9:0];
			REG_MIN_SHARE: min_share_q = value[8:0];
			REG_UNC_LIMIT: unc_limit_q = value;
			REG_BELOW_LIM: below_limit_q = value[9:0];
			REG_JAG_LIMIT: jag_limit_q = value[17:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [23:0] top, input logic [23:0] share,
			input logic [23:0] unc, input logic [23:0] below, input logic [23:0] jag);
		wait_idle();
		write_reg(REG_TOP_LINE, top);
		write_reg(REG_MIN_SHARE, share);
		write_reg(REG_UNC_LIMIT, unc);
		write_reg(REG_BELOW_LIM, below);
		write_reg(REG_JAG_LIMIT, jag);
		write_reg(RegUnused, 24'($urandom()));
	endtask

	// one list; style 0 smooth, 1 noise, 2 flat columns (zero dx)
	task automatic send_list(input int len, input int style);
		logic [9:0] x, y;
		int step;
		x = 10'($urandom_range(0, 300));
		y = 10'($urandom_range(0, 1023));
		for (int i = 0; i < len; i++) begin
			if (style == 1) begin
				x = 10'($urandom());
				y = 10'($urandom());
			end else if (style == 0 && i > 0) begin
				step = $urandom_range(0, 40);
				x = (int'(x) + step > 1023) ? 10'd1023 : 10'(int'(x) + step);
				y = 10'(int'(y) + $urandom_range(0, 60) - 30);
			end
			send_spot(x, y, ($urandom_range(0, 3) == 0) ? 24'($urandom())
				: 24'($urandom_range(0, 6000)), i == len - 1);
		end
	endtask

	task automatic test_defaults();
		send_list(8, 0);
		send_list(5, 1);
	endtask

	task automatic test_short_lists();
		send_spot(10'd5, 10'd700, 24'd100, 1'b1);
		send_spot(10'd5, 10'd700, 24'd100, 1'b0);
		send_spot(10'd9, 10'd710, 24'd100, 1'b1);
	endtask

	task automatic test_extremes();
		send_spot(10'd0, 10'd1023, 24'hFFFFFF, 1'b0);
		send_spot(10'd512, 10'd0, 24'd0, 1'b0);
		send_spot(10'd1023, 10'd1023, 24'hFFFFFF, 1'b0);
		send_spot(10'd1023, 10'd1, 24'd0, 1'b1);
		send_spot(10'd0, 10'd0, 24'd0, 1'b0);
		send_spot(10'd1023, 10'd1023, 24'd0, 1'b0);
		send_spot(10'd0, 10'd0, 24'hFFFFFF, 1'b1);
	endtask

	task automatic test_no_counted();
		set_regs(24'd1023, 24'd256, 24'd0, 24'd0, 24'd0);
		send_list(4, 1);
		set_regs(24'd500, 24'd0, 24'd2560, 24'd20, 24'd1280);
		for (int i = 0; i < 4; i++)
			send_spot(10'(i * 50), 10'($urandom_range(0, 500)), 24'd9, i == 3);
	endtask

	task automatic test_zero_dx();
		set_regs(24'd0, 24'd128, 24'd2560, 24'd20, 24'd0);
		send_list(6, 2);
		send_list(20, 2);
	endtask

	task automatic test_over_capacity();
		set_regs(24'd0, 24'd128, 24'hFFFFFF, 24'd1023, 24'h3FFFF);
		send_list(64, 0);
		send_list(70, 0);
		send_list(70, 1);
	endtask

	task automatic test_backpressure();
		wait_idle();
		hold_req = 1;
		repeat (4) send_list($urandom_range(3, 6), 0);
	endtask

	task automatic test_random();
		int phase, len, style;
		phase = 0;
		while (spots_sent < 1550) begin
			case (phase % 6)
				0: set_regs(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
				1: set_regs(24'h3FF, 24'h1FF, 24'hFFFFFF, 24'h3FF, 24'h3FFFF);
				default: set_regs(24'($urandom_range(0, 600)), 24'($urandom_range(0, 256)),
					24'($urandom_range(0, 8000)), 24'($urandom_range(0, 60)),
					24'($urandom_range(0, 4000)));
			endcase
			for (int k = 0; k < 15; k++) begin
				case ($urandom_range(0, 9))
					0: len = $urandom_range(1, 2);
					1: len = $urandom_range(60, 68);
					default: len = $urandom_range(3, 24);
				endcase
				style = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2);
				send_list(len, style);
			end
			phase++;
		end
	endtask

	initial begin
		top_line_q = 10'd0;
		min_share_q = 9'd128;
		unc_limit_q = 24'd2560;
		below_limit_q = 10'd20;
		jag_limit_q = 18'd1280;
		clear_list();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_short_lists();
		test_extremes();
		test_no_counted();
		test_zero_dx();
		test_over_capacity();
		test_backpressure();
		test_random();
		wait_idle();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/bpc_pkg.sv
design/bpc_divider.sv
design/bpc_row_ram.sv
design/boundary_plausibility_check_unit.sv
verif/boundary_plausibility_check_unit_test.sv
